FILE: hw/rtl/bsst_pkg.sv
// Shared types and constants for the bounded set span tracker.
package bsst_pkg;

  localparam int unsigned ValW  = 32;
  localparam int unsigned SpanW = 31;
  localparam int unsigned StatW = 3;
  localparam int unsigned OpW   = 2;
  localparam int unsigned CapW  = 9;

  localparam logic [OpW-1:0] OP_ADD_VALUE = 2'd0;
  localparam logic [OpW-1:0] OP_ADD_RUN   = 2'd1;
  localparam logic [OpW-1:0] OP_SHORTEST  = 2'd2;
  localparam logic [OpW-1:0] OP_LONGEST   = 2'd3;

  localparam logic [StatW-1:0] ST_OK         = 3'd0;
  localparam logic [StatW-1:0] ST_FULL       = 3'd1;
  localparam logic [StatW-1:0] ST_WRONG      = 3'd2;
  localparam logic [StatW-1:0] ST_NOT_ENOUGH = 3'd3;
  localparam logic [StatW-1:0] ST_OFF_LIMITS = 3'd4;

  // broadcast from the control to every cell
  typedef struct packed {
    logic            ins_en;
    logic [ValW-1:0] x;
    logic            scan_load;
  } cell_ctrl_t;

  // what a cell shows its right-hand neighbor
  typedef struct packed {
    logic            valid;
    logic            gt;
    logic [ValW-1:0] val;
  } cell_link_t;

endpackage

FILE: hw/rtl/bsst_in_if.sv
// Request channel: opcode and operands.
interface bsst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] value;
  logic [31:0] range_end;

  modport source (output valid, output opcode, output value, output range_end, input ready);
  modport sink   (input valid, input opcode, input value, input range_end, output ready);
endinterface

FILE: hw/rtl/bsst_out_if.sv
// Result channel: span and status.
interface bsst_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] span;
  logic [2:0]  status;

  modport source (output valid, output span, output status, input ready);
  modport sink   (input valid, input span, input status, output ready);
endinterface

FILE: hw/rtl/bsst_cfg_if.sv
// Configuration write channel: capacity register data.
interface bsst_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bsst_cell.sv
// One cell of the sorted insertion chain, with its min-gap scan register.
module bsst_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsst_pkg::cell_ctrl_t          ctrl_i,
  input  bsst_pkg::cell_link_t          left_i,
  input  logic [bsst_pkg::ValW-1:0]     right_mn_i,
  output bsst_pkg::cell_link_t          link_o,
  output logic [bsst_pkg::ValW-1:0]     mn_o
);
  import bsst_pkg::*;

  logic            valid_q, valid_d;
  logic [ValW-1:0] val_q, val_d;
  logic [ValW-1:0] mn_q, mn_d;
  logic            gt;
  logic            take;
  logic [ValW-1:0] gap;

  assign gt   = valid_q && ($signed(val_q) > $signed(ctrl_i.x));
  // shift right if larger than x, or become the first free slot
  assign take = ctrl_i.ins_en && (gt || (!valid_q && left_i.valid));

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (take) begin
      val_d   = left_i.gt ? left_i.val : ctrl_i.x;
      valid_d = 1'b1;
    end
  end

  // neighbors in sorted order, so the gap is never negative
  assign gap = val_q - left_i.val;

  always_comb begin
    if (ctrl_i.scan_load) begin
      mn_d = valid_q ? gap : '1;
    end else begin
      mn_d = (right_mn_i < mn_q) ? right_mn_i : mn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    mn_q  <= mn_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.gt    = gt;
  assign link_o.val   = val_q;
  assign mn_o         = mn_q;

endmodule

FILE: hw/rtl/bounded_set_span_tracker_unit.sv
// Bounded sorted multiset with shortest/longest span queries.
//
// Channels: cfg_i writes the 9-bit capacity (always ready, write only when
// idle). in_i takes requests {opcode, value, range_end}; out_o returns one
// {span, status} result per request, in request order.
// The values sit in a row of MAX_VALUES cells kept in ascending order; a new
// value is compared against every cell at once and the larger ones move one
// cell to the right.
// Per request:
//   add value      : result registered; the block stays idle for the next request.
//   add run a..b-1 : result registered on acceptance; the block then inserts one
//                    value per cycle and takes no new request until the run is done.
//   longest span   : result registered (tracked maximum minus the first cell).
//   shortest span  : the per-cell gap minimum travels one cell per cycle toward
//                    the head of the row, and cell 1 gives the result.
// A result waits in the output register while the receiver stalls; a new
// request is taken only while that register is free or being emptied.
// Reset empties the set and clears capacity to zero; no clearing pass.
module bounded_set_span_tracker_unit #(
  parameter int unsigned MAX_VALUES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsst_cfg_if.sink   cfg_i,
  bsst_in_if.sink    in_i,
  bsst_out_if.source out_o
);
  import bsst_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_VALUES + 1);
  localparam int unsigned LimW = (CntW > CapW) ? CntW : CapW;
  localparam int unsigned CmpW = ValW + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SCAN
  } state_e;

  state_e           state_q;
  logic [CapW-1:0]  cap_q;
  logic [CntW-1:0]  count_q;
  logic [ValW-1:0]  max_q;
  logic [ValW-1:0]  run_val_q;
  logic [CntW-1:0]  run_left_q;
  logic [CntW-1:0]  scan_cnt_q;
  logic             out_valid_q;
  logic [SpanW-1:0] out_span_q;
  logic [StatW-1:0] out_status_q;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic [LimW-1:0]  lim;
  logic             has_room;
  logic [ValW:0]    diff;
  logic             run_wrong;
  logic             run_full;
  logic             few;
  logic [ValW-1:0]  longest;
  cell_ctrl_t       ctrl;

  cell_link_t       links [MAX_VALUES];
  cell_link_t       lefts [MAX_VALUES];
  logic [ValW-1:0]  mns   [MAX_VALUES];
  logic [ValW-1:0]  rmns  [MAX_VALUES];

  assign cfg_i.ready = 1'b1;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  assign lim = (LimW'(cap_q) > LimW'(MAX_VALUES)) ? LimW'(MAX_VALUES) : LimW'(cap_q);
  assign has_room  = LimW'(count_q) < lim;
  assign diff      = {in_i.range_end[ValW-1], in_i.range_end} - {in_i.value[ValW-1], in_i.value};
  assign run_wrong = diff[ValW];
  assign run_full  = (CmpW'(count_q) + CmpW'(diff)) > CmpW'(lim);
  assign few       = count_q < CntW'(2);
  assign longest   = max_q - links[0].val;

  always_comb begin
    ctrl.ins_en    = (state_q == S_RUN) ||
                     (in_acc && (in_i.opcode == OP_ADD_VALUE) && has_room);
    ctrl.x         = (state_q == S_RUN) ? run_val_q : in_i.value;
    ctrl.scan_load = in_acc && (in_i.opcode == OP_SHORTEST) && !few;
  end

  // every accepted request answers at once except a shortest-span scan
  assign out_load = (in_acc && !ctrl.scan_load) ||
                    ((state_q == S_SCAN) && (scan_cnt_q == '0) && out_free);

  for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lefts[i] = '{valid: 1'b1, gt: 1'b0, val: '0};
    end else begin : g_body
      assign lefts[i] = links[i-1];
    end
    if (i == MAX_VALUES - 1) begin : g_tail
      assign rmns[i] = '1;
    end else begin : g_mid
      assign rmns[i] = mns[i+1];
    end

    bsst_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .left_i     (lefts[i]),
      .right_mn_i (rmns[i]),
      .link_o     (links[i]),
      .mn_o       (mns[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cap_q        <= '0;
      count_q      <= '0;
      max_q        <= '0;
      run_val_q    <= '0;
      run_left_q   <= '0;
      scan_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      out_span_q   <= '0;
      out_status_q <= ST_OK;
    end else begin
      if (cfg_i.valid) begin
        cap_q <= cfg_i.data;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl.ins_en) begin
        count_q <= count_q + CntW'(1);
        if ((count_q == '0) || ($signed(ctrl.x) > $signed(max_q))) begin
          max_q <= ctrl.x;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (in_i.opcode)
              OP_ADD_VALUE: begin
                out_span_q   <= '0;
                out_status_q <= has_room ? ST_OK : ST_FULL;
              end
              OP_ADD_RUN: begin
                out_span_q <= '0;
                if (run_wrong) begin
                  out_status_q <= ST_WRONG;
                end else if (run_full) begin
                  out_status_q <= ST_FULL;
                end else begin
                  out_status_q <= ST_OK;
                  if (diff != '0) begin
                    run_val_q  <= in_i.value;
                    run_left_q <= diff[CntW-1:0];
                    state_q    <= S_RUN;
                  end
                end
              end
              OP_SHORTEST: begin
                if (few) begin
                  out_span_q   <= '0;
                  out_status_q <= ST_NOT_ENOUGH;
                end else begin
                  scan_cnt_q <= count_q;
                  state_q    <= S_SCAN;
                end
              end
              default: begin
                if (few) begin
                  out_span_q   <= '0;
                  out_status_q <= ST_NOT_ENOUGH;
                end else if (longest[ValW-1]) begin
                  out_span_q   <= '0;
                  out_status_q <= ST_OFF_LIMITS;
                end else begin
                  out_status_q <= ST_OK;
                  out_span_q   <= longest[SpanW-1:0];
                end
              end
            endcase
          end
        end
        S_RUN: begin
          run_val_q  <= run_val_q + ValW'(1);
          run_left_q <= run_left_q - CntW'(1);
          if (run_left_q == CntW'(1)) begin
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          // cell 1 collects the minimum of all gaps from itself rightward
          if (scan_cnt_q != '0) begin
            scan_cnt_q <= scan_cnt_q - CntW'(1);
          end else if (out_free) begin
            if (mns[1][ValW-1]) begin
              out_status_q <= ST_OFF_LIMITS;
              out_span_q   <= '0;
            end else begin
              out_status_q <= ST_OK;
              out_span_q   <= mns[1][SpanW-1:0];
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.span   = out_span_q;
  assign out_o.status = out_status_q;

endmodule

FILE: hw/rtl/bsst_checker.sv
// Port-level checks for the span tracker, bound to the top level.
module bsst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_opcode_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [30:0] out_span_i,
  input logic [2:0]  out_status_i
);
  import bsst_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_span_i) &&
      $stable(out_status_i))
    else $error("result changed while stalled");

  // only a successful query carries a span
  a_span_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> (out_span_i == '0))
    else $error("nonzero span with error status");

  // every request but a shortest-span query answers in the next cycle
  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i != OP_SHORTEST) |=> out_valid_i)
    else $error("missing next-cycle result");

  // single adds never report query-only statuses
  a_add_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == OP_ADD_VALUE) |=>
      (out_status_i == ST_OK) || (out_status_i == ST_FULL))
    else $error("bad status for single add");

endmodule

bind bounded_set_span_tracker_unit bsst_checker u_bsst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_span_i   (out_o.span),
  .out_status_i (out_o.status)
);
